@@ src/fftps_pkg.sv @@
// shared types and constants for the fft power spectrum block
// state encoding, arithmetic widths and the per-stage twiddle step table
// no dependencies
`default_nettype none
package fftps_pkg;

  localparam int SAMPLE_W = 16;
  localparam int A_W      = 17;
  localparam int TW_W     = 18;
  localparam int T_W      = 19;
  localparam int PROD_W   = A_W + TW_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int FRAC_W   = 15;
  localparam int STAGE_W  = 4;
  localparam int WORD_W   = 2 * SAMPLE_W;
  localparam int POWER_W  = 17;
  localparam int BIN_W    = 10;
  localparam logic signed [TW_W-1:0] TW_ONE = 18'sd32767;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RV_CHECK,
    ST_RV_STEP,
    ST_RV_RD_I,
    ST_RV_RD_R,
    ST_RV_WR_I,
    ST_RV_WR_R,
    ST_BF_INIT,
    ST_BF_CHECK,
    ST_BF_RD_P,
    ST_BF_RD_K,
    ST_BF_MUL,
    ST_BF_WR_P,
    ST_BF_WR_K,
    ST_TW_MUL,
    ST_TW_SUM,
    ST_TW_UPD,
    ST_RD_SQ,
    ST_RD_OUT
  } state_t;

  function automatic logic signed [A_W-1:0] step_re(input logic [STAGE_W-1:0] s);
    logic signed [A_W-1:0] v;
    case (s)
      4'd1:    v = -17'sd32768;
      4'd2:    v = 17'sd0;
      4'd3:    v = 17'sd23171;
      4'd4:    v = 17'sd30274;
      4'd5:    v = 17'sd32139;
      4'd6:    v = 17'sd32610;
      4'd7:    v = 17'sd32729;
      4'd8:    v = 17'sd32758;
      4'd9:    v = 17'sd32766;
      4'd10:   v = 17'sd32767;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [A_W-1:0] step_im(input logic [STAGE_W-1:0] s);
    logic signed [A_W-1:0] v;
    case (s)
      4'd1:    v = 17'sd0;
      4'd2:    v = -17'sd32767;
      4'd3:    v = -17'sd23171;
      4'd4:    v = -17'sd12540;
      4'd5:    v = -17'sd6393;
      4'd6:    v = -17'sd3212;
      4'd7:    v = -17'sd1608;
      4'd8:    v = -17'sd804;
      4'd9:    v = -17'sd402;
      4'd10:   v = -17'sd201;
      default: v = 17'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ src/fixed_point_fft_power_spectrum.sv @@
// fixed-point fft power spectrum: loads a frame, runs an in-place radix-2 fft
// out of one word-wide memory, then returns bin powers on read items
// depends on fftps_pkg and fftps_cmul
// load items are accepted while idle and no result waits; the frame's last load starts
// the transform, which holds s_tready low while each butterfly reads both points,
// multiplies and writes both back, each twiddle update multiplies, sums and updates, and
// each reorder step swaps or advances, all through the single memory port; a read item's
// result is registered in RD_SQ, then RD_OUT, and a waiting result holds s_tready low
// reset (synchronous) clears counters and flags; store contents are undefined until loaded
`default_nettype none
module fixed_point_fft_power_spectrum #(
  parameter int N_POINTS = 1024
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,   // sample
  input  wire  [0:0]  s_tuser,   // action
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // bin_index, power, zero pad
  output logic        m_tlast,   // last_bin
  output logic [1:0]  m_tuser    // ready_res, overflow
);
  import fftps_pkg::*;

  localparam int AW = (N_POINTS > 1) ? $clog2(N_POINTS) : 1;
  localparam int CW = AW + 2;
  localparam int LW = AW + 1;
  localparam logic [CW-1:0] NC   = CW'(N_POINTS);
  localparam logic [CW-1:0] HALF = CW'(N_POINTS / 2);

  state_t state, state_next;

  logic [WORD_W-1:0] mem [N_POINTS];
  logic [WORD_W-1:0] rdata, wdata;
  logic [AW-1:0]     raddr, waddr;
  logic              wen;

  logic [LW-1:0] load_count;
  logic [AW-1:0] read_index;
  logic          spectrum_ready, overflow_seen;

  logic [CW-1:0] ri, rev, kk, k, g, span;
  logic [STAGE_W-1:0] stage;
  logic [WORD_W-1:0]  di;
  logic signed [SAMPLE_W-1:0] ar, ai;
  logic signed [TW_W-1:0] wr, wi;
  logic [WORD_W-1:0] kdata;
  logic signed [A_W-1:0] ma_re, ma_im;
  logic signed [T_W-1:0] y_re, y_im;
  logic [2*SAMPLE_W-1:0] sq_re, sq_im;

  logic accept, do_load, do_read;
  logic [CW-1:0] p;
  logic signed [T_W:0] dp_re, dp_im, dk_re, dk_im;
  logic ovf_bf;

  assign accept  = s_tvalid && s_tready;
  assign do_load = accept && !s_tuser[0] && !spectrum_ready && (load_count < LW'(N_POINTS));
  assign do_read = accept && s_tuser[0] && spectrum_ready;
  assign p       = k + span;

  assign dp_re = (T_W+1)'(ar) - (T_W+1)'(y_re);
  assign dp_im = (T_W+1)'(ai) - (T_W+1)'(y_im);
  assign dk_re = (T_W+1)'(ar) + (T_W+1)'(y_re);
  assign dk_im = (T_W+1)'(ai) + (T_W+1)'(y_im);
  assign ovf_bf =
    (dp_re[T_W:SAMPLE_W-1] != '0 && dp_re[T_W:SAMPLE_W-1] != '1) ||
    (dp_im[T_W:SAMPLE_W-1] != '0 && dp_im[T_W:SAMPLE_W-1] != '1) ||
    (dk_re[T_W:SAMPLE_W-1] != '0 && dk_re[T_W:SAMPLE_W-1] != '1) ||
    (dk_im[T_W:SAMPLE_W-1] != '0 && dk_im[T_W:SAMPLE_W-1] != '1);

  fftps_cmul u_cmul (
    .clk  (clk),
    .a_re (ma_re),
    .a_im (ma_im),
    .b_re (wr),
    .b_im (wi),
    .y_re (y_re),
    .y_im (y_im)
  );

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (do_load && load_count == LW'(N_POINTS - 1)) state_next = ST_RV_CHECK;
        else if (do_read) state_next = ST_RD_SQ;
      end
      ST_RV_CHECK: begin
        if (ri + CW'(2) > NC) state_next = ST_BF_INIT;
        else if (ri < rev && rev < NC) state_next = ST_RV_RD_I;
        else state_next = ST_RV_STEP;
      end
      ST_RV_STEP:  if (!(kk != '0 && rev >= kk)) state_next = ST_RV_CHECK;
      ST_RV_RD_I:  state_next = ST_RV_RD_R;
      ST_RV_RD_R:  state_next = ST_RV_WR_I;
      ST_RV_WR_I:  state_next = ST_RV_WR_R;
      ST_RV_WR_R:  state_next = ST_RV_STEP;
      ST_BF_INIT:  state_next = ST_BF_CHECK;
      ST_BF_CHECK: state_next = (p < NC) ? ST_BF_RD_P : ST_TW_MUL;
      ST_BF_RD_P:  state_next = ST_BF_RD_K;
      ST_BF_RD_K:  state_next = ST_BF_MUL;
      ST_BF_MUL:   state_next = ST_BF_WR_P;
      ST_BF_WR_P:  state_next = ST_BF_WR_K;
      ST_BF_WR_K:  state_next = ST_BF_CHECK;
      ST_TW_MUL:   state_next = ST_TW_SUM;
      ST_TW_SUM:   state_next = ST_TW_UPD;
      ST_TW_UPD: begin
        if (g + CW'(1) == span && (span << 2) > NC) state_next = ST_IDLE;
        else state_next = ST_BF_CHECK;
      end
      ST_RD_SQ:    state_next = ST_RD_OUT;
      ST_RD_OUT:   state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    wen      = 1'b0;
    waddr    = '0;
    wdata    = '0;
    raddr    = '0;
    ma_re    = A_W'(signed'(rdata[WORD_W-1:SAMPLE_W]));
    ma_im    = A_W'(signed'(rdata[SAMPLE_W-1:0]));
    case (state)
      ST_IDLE: begin
        s_tready = !m_tvalid;
        raddr    = read_index;
        if (do_load) begin
          wen   = 1'b1;
          waddr = load_count[AW-1:0];
          wdata = {s_tdata, {SAMPLE_W{1'b0}}};
        end
      end
      ST_RV_RD_I: raddr = ri[AW-1:0];
      ST_RV_RD_R: raddr = rev[AW-1:0];
      ST_RV_WR_I: begin
        wen   = 1'b1;
        waddr = ri[AW-1:0];
        wdata = rdata;
      end
      ST_RV_WR_R: begin
        wen   = 1'b1;
        waddr = rev[AW-1:0];
        wdata = di;
      end
      ST_BF_RD_P: raddr = p[AW-1:0];
      ST_BF_RD_K: raddr = k[AW-1:0];
      ST_BF_WR_P: begin
        wen   = 1'b1;
        waddr = p[AW-1:0];
        wdata = {dp_re[SAMPLE_W-1:0], dp_im[SAMPLE_W-1:0]};
      end
      ST_BF_WR_K: begin
        wen   = 1'b1;
        waddr = k[AW-1:0];
        wdata = kdata;
      end
      ST_TW_MUL: begin
        ma_re = step_re(stage);
        ma_im = step_im(stage);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      load_count     <= '0;
      read_index     <= '0;
      spectrum_ready <= 1'b0;
      overflow_seen  <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (do_load) begin
            load_count <= load_count + LW'(1);
            if (load_count == '0) overflow_seen <= 1'b0;
          end
          if (accept && s_tuser[0] && !spectrum_ready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= '0;
            m_tlast  <= 1'b0;
            m_tuser  <= '0;
          end
        end
        ST_BF_WR_P: if (ovf_bf) overflow_seen <= 1'b1;
        ST_TW_UPD: begin
          if (g + CW'(1) == span && (span << 2) > NC) begin
            spectrum_ready <= 1'b1;
            read_index     <= '0;
          end
        end
        ST_RD_OUT: begin
          m_tvalid <= 1'b1;
          m_tdata  <= {{(32 - BIN_W - POWER_W){1'b0}},
                       POWER_W'(sq_re[2*SAMPLE_W-2:FRAC_W]) +
                       POWER_W'(sq_im[2*SAMPLE_W-2:FRAC_W]),
                       BIN_W'(read_index)};
          m_tlast  <= (read_index == AW'(N_POINTS - 1));
          m_tuser  <= {overflow_seen, 1'b1};
          if (read_index == AW'(N_POINTS - 1)) begin
            read_index     <= '0;
            load_count     <= '0;
            spectrum_ready <= 1'b0;
          end else begin
            read_index <= read_index + AW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // transform sequencing registers and read squaring registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        ri  <= CW'(1);
        rev <= HALF;
        kk  <= HALF;
      end
      ST_RV_STEP: begin
        if (kk != '0 && rev >= kk) begin
          rev <= rev - kk;
          kk  <= kk >> 1;
        end else begin
          rev <= rev + kk;
          ri  <= ri + CW'(1);
          kk  <= HALF;
        end
      end
      ST_RV_WR_I: ;
      ST_RV_RD_R: di <= rdata;
      ST_BF_INIT: begin
        stage <= STAGE_W'(1);
        span  <= CW'(1);
        g     <= '0;
        k     <= '0;
        wr    <= TW_ONE;
        wi    <= '0;
      end
      ST_BF_MUL: begin
        ar <= signed'(rdata[WORD_W-1:SAMPLE_W]);
        ai <= signed'(rdata[SAMPLE_W-1:0]);
      end
      ST_BF_WR_P: kdata <= {dk_re[SAMPLE_W-1:0], dk_im[SAMPLE_W-1:0]};
      ST_BF_WR_K: k <= k + (span << 1);
      ST_TW_UPD: begin
        if (g + CW'(1) == span) begin
          stage <= stage + STAGE_W'(1);
          span  <= span << 1;
          g     <= '0;
          k     <= '0;
          wr    <= TW_ONE;
          wi    <= '0;
        end else begin
          g  <= g + CW'(1);
          k  <= g + CW'(1);
          wr <= y_re[TW_W-1:0];
          wi <= y_im[TW_W-1:0];
        end
      end
      ST_RD_SQ: begin
        sq_re <= signed'(rdata[WORD_W-1:SAMPLE_W]) * signed'(rdata[WORD_W-1:SAMPLE_W]);
        sq_im <= signed'(rdata[SAMPLE_W-1:0]) * signed'(rdata[SAMPLE_W-1:0]);
      end
      default: ;
    endcase
  end

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    spectrum_ready |-> load_count == LW'(N_POINTS))
    else $error("spectrum ready without a full frame");

  a_no_load_when_ready: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && wen) |-> !spectrum_ready)
    else $error("sample stored while spectrum ready");

  a_quiet_during_fft: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && state != ST_RD_SQ && state != ST_RD_OUT) |-> !m_tvalid)
    else $error("result pending during transform");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> !spectrum_ready)
    else $error("frame still ready after last bin");

  a_read_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD_OUT) |=> m_tvalid && m_tuser[0])
    else $error("read result missing");

endmodule
`default_nettype wire

@@ src/fftps_cmul.sv @@
// q15 complex multiplier, two register stages
// products first, then sums divided by 32768 with truncation toward zero
// depends on fftps_pkg
`default_nettype none
module fftps_cmul (
  input  wire                                clk,
  input  wire logic signed [fftps_pkg::A_W-1:0]  a_re,
  input  wire logic signed [fftps_pkg::A_W-1:0]  a_im,
  input  wire logic signed [fftps_pkg::TW_W-1:0] b_re,
  input  wire logic signed [fftps_pkg::TW_W-1:0] b_im,
  output logic signed [fftps_pkg::T_W-1:0]       y_re,
  output logic signed [fftps_pkg::T_W-1:0]       y_im
);
  import fftps_pkg::*;

  logic signed [PROD_W-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [SUM_W-1:0]  s_re, s_im;

  function automatic logic signed [T_W-1:0] q15_div(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] q;
    q = v >>> FRAC_W;
    if (v[SUM_W-1] && (v[FRAC_W-1:0] != '0)) q = q + SUM_W'(1);
    return q[T_W-1:0];
  endfunction

  assign s_re = SUM_W'(p_rr) - SUM_W'(p_ii);
  assign s_im = SUM_W'(p_ri) + SUM_W'(p_ir);

  always_ff @(posedge clk) begin
    p_rr <= a_re * b_re;
    p_ii <= a_im * b_im;
    p_ri <= a_re * b_im;
    p_ir <= a_im * b_re;
    y_re <= q15_div(s_re);
    y_im <= q15_div(s_im);
  end

endmodule
`default_nettype wire
